@@ hdl/nni_pkg.sv @@
// package for the nearest neighbor interchange test block
// holds fixed widths, swap direction codes; no dependencies
package nni_pkg;
	localparam int SIZE_W   = 11;
	localparam int DIST_W   = 32;
	localparam int LAM_BITS = 18;
	localparam int CHG_W    = 35;
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [DIST_W-1:0] dist_t;
endpackage

@@ hdl/nni_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// computes floor(num * 2^18 / den), quotient in [0, 2^19 - 1] when num < 2 * den; uses nni_pkg
module nni_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 24,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [nni_pkg::LAM_BITS:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	import nni_pkg::*;
	localparam int QW = LAM_BITS + 1;
	localparam int RW = DEN_W + 1;
	// remainder starts as num; quotient bits from 2^18 down to 2^0
	logic [QW:1]      v_q;
	logic [RW-1:0]    r_q  [1:QW];
	logic [DEN_W-1:0] d_q  [1:QW];
	logic [QW-1:0]    qb_q [1:QW];
	logic [TAG_W-1:0] t_q  [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_st
		logic             v_in;
		logic [RW-1:0]    r_in;
		logic [DEN_W-1:0] d_in;
		logic [QW-1:0]    q_in;
		logic [TAG_W-1:0] t_in;
		logic [RW-1:0] sh;
		logic [RW:0]   diff;
		logic [RW-1:0] rs;
		logic [QW-1:0] qs;
		if (i == 0) begin : g_in
			assign v_in = in_valid;
			assign r_in = RW'(num);
			assign d_in = den;
			assign q_in = '0;
			assign t_in = tag_in;
		end else begin : g_in
			assign v_in = v_q[i];
			assign r_in = r_q[i];
			assign d_in = d_q[i];
			assign q_in = qb_q[i];
			assign t_in = t_q[i];
		end
		always_comb begin
			// bit weight 2^(18-i): compare r against den shifted by that
			sh = (i == 0) ? r_in : r_in << 1;
			diff = {1'b0, sh} - {2'b0, d_in};
			if (!diff[RW]) begin
				qs = q_in | (QW'(1) << (QW-1-i));
				rs = diff[RW-1:0];
			end else begin
				qs = q_in;
				rs = sh;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (en) v_q[i+1] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i+1]  <= rs;
				d_q[i+1]  <= d_in;
				qb_q[i+1] <= qs;
				t_q[i+1]  <= t_in;
			end
		end
	end

	assign out_valid = v_q[QW];
	assign quo       = qb_q[QW];
	assign tag_out   = t_q[QW];
endmodule

@@ hdl/nni_swap_test.sv @@
// Nearest neighbor interchange test for one internal tree edge under OLS
// weighting. A transaction enters every cycle unless m_axis stalls; the
// pipeline is three stages of clamping, pair sums and size products, nineteen
// stages of the bit-per-stage lambda dividers, two weight stages, a compare
// stage and the output register.
// Backpressure on m_axis stalls the whole pipeline through one global enable.
// Depends on nni_pkg and nni_div.
module nni_swap_test #(
	parameter int MAX_LEAF_COUNT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: size_above, size_sibling, size_left, size_right, dist_left_right,
	// dist_left_up, dist_left_down, dist_right_up, dist_right_down, dist_down_up
	input  logic [239:0] s_axis_tdata,
	// tuser: tail_is_leaf, head_is_leaf
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: weight_change
	output logic [39:0]  m_axis_tdata,
	// tuser: swap_direction
	output logic [1:0]   m_axis_tuser
);
	import nni_pkg::*;
	localparam int CW  = $clog2(MAX_LEAF_COUNT + 1);
	localparam int PW  = 2 * CW;
	localparam int NW  = PW + 1;
	localparam int DW  = 2 * (CW + 1);
	localparam int SW  = DIST_W + 1;
	localparam int TW  = 1 + 3 * SW;
	localparam int WW  = SW + LAM_BITS + 2;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	function automatic logic [CW-1:0] clamp(input size_t s);
		if (s == '0) return CW'(1);
		if (32'(s) > MAX_LEAF_COUNT) return CW'(MAX_LEAF_COUNT);
		return CW'(s);
	endfunction

	// stage 1: clamp, pair sums
	logic v_s1, skip_s1;
	logic [CW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic [SW-1:0] p0_s1, q0_s1, r0_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			skip_s1 <= s_axis_tuser[0] | s_axis_tuser[1];
			a_s1 <= clamp(s_axis_tdata[10:0]);
			b_s1 <= clamp(s_axis_tdata[21:11]);
			c_s1 <= clamp(s_axis_tdata[32:22]);
			d_s1 <= clamp(s_axis_tdata[43:33]);
			// lu+rd, ru+ld, du+lr
			p0_s1 <= SW'(s_axis_tdata[107:76]) + SW'(s_axis_tdata[203:172]);
			q0_s1 <= SW'(s_axis_tdata[171:140]) + SW'(s_axis_tdata[139:108]);
			r0_s1 <= SW'(s_axis_tdata[235:204]) + SW'(s_axis_tdata[75:44]);
		end
	end

	// stage 2: size products and size pair sums
	logic v_s2, skip_s2;
	logic [SW-1:0] p0_s2, q0_s2, r0_s2;
	logic [PW-1:0] bc_s2, ad_s2, cd_s2, ab_s2;
	logic [CW:0] ab1_s2, cd1_s2, ac_s2, bd_s2, adsum_s2, bcsum_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			skip_s2 <= skip_s1;
			p0_s2 <= p0_s1; q0_s2 <= q0_s1; r0_s2 <= r0_s1;
			bc_s2 <= b_s1 * c_s1; ad_s2 <= a_s1 * d_s1;
			cd_s2 <= c_s1 * d_s1; ab_s2 <= a_s1 * b_s1;
			ab1_s2 <= (CW+1)'(a_s1) + (CW+1)'(b_s1);
			cd1_s2 <= (CW+1)'(c_s1) + (CW+1)'(d_s1);
			ac_s2 <= (CW+1)'(a_s1) + (CW+1)'(c_s1);
			bd_s2 <= (CW+1)'(b_s1) + (CW+1)'(d_s1);
			adsum_s2 <= (CW+1)'(a_s1) + (CW+1)'(d_s1);
			bcsum_s2 <= (CW+1)'(b_s1) + (CW+1)'(c_s1);
		end
	end

	// stage 3: numerators and denominators
	logic v_s3, skip_s3;
	logic [SW-1:0] p0_s3, q0_s3, r0_s3;
	logic [NW-1:0] n01_s3, n2_s3;
	logic [DW-1:0] d0_s3, d1_s3, d2_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			skip_s3 <= skip_s2;
			p0_s3 <= p0_s2; q0_s3 <= q0_s2; r0_s3 <= r0_s2;
			n01_s3 <= NW'(bc_s2) + NW'(ad_s2);
			n2_s3  <= NW'(cd_s2) + NW'(ab_s2);
			d0_s3 <= ab1_s2 * cd1_s2;
			d1_s3 <= ac_s2 * bd_s2;
			d2_s3 <= adsum_s2 * bcsum_s2;
		end
	end

	logic [TW-1:0] tag_in, tag_o, tag_x1, tag_x2;
	assign tag_in = {skip_s3, p0_s3, q0_s3, r0_s3};
	logic dv0, dv1, dv2;
	logic [LAM_BITS:0] l0, l1, l2;
	nni_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div0 (
		.clk, .arst_n, .en, .in_valid(v_s3), .num(n01_s3), .den(d0_s3),
		.tag_in, .out_valid(dv0), .quo(l0), .tag_out(tag_o));
	nni_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div1 (
		.clk, .arst_n, .en, .in_valid(v_s3), .num(n01_s3), .den(d1_s3),
		.tag_in, .out_valid(dv1), .quo(l1), .tag_out(tag_x1));
	nni_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(TW)) u_div2 (
		.clk, .arst_n, .en, .in_valid(v_s3), .num(n2_s3), .den(d2_s3),
		.tag_in, .out_valid(dv2), .quo(l2), .tag_out(tag_x2));

	logic skip_d;
	logic [SW-1:0] ps, qs, rs;
	assign {skip_d, ps, qs, rs} = tag_o;
	logic [LAM_BITS:0] one;
	assign one = (LAM_BITS+1)'(1) << LAM_BITS;

	// stage 4: lambda products, w = L*P + (1-L)*Q + R<<18
	logic v_s4, skip_s4;
	logic [WW-1:0] a0_s4, b0_s4, a1_s4, b1_s4, a2_s4, b2_s4, r0_s4, r1_s4, r2_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= dv0 & dv1 & dv2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			skip_s4 <= skip_d;
			a0_s4 <= WW'(l0) * WW'(ps); b0_s4 <= WW'(one - l0) * WW'(qs);
			a1_s4 <= WW'(l1) * WW'(rs); b1_s4 <= WW'(one - l1) * WW'(qs);
			a2_s4 <= WW'(l2) * WW'(ps); b2_s4 <= WW'(one - l2) * WW'(rs);
			r0_s4 <= WW'(rs) << LAM_BITS;
			r1_s4 <= WW'(ps) << LAM_BITS;
			r2_s4 <= WW'(qs) << LAM_BITS;
		end
	end

	// stage 5: weights
	logic v_s5, skip_s5;
	logic [WW-1:0] w0_s5, w1_s5, w2_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			skip_s5 <= skip_s4;
			w0_s5 <= a0_s4 + b0_s4 + r0_s4;
			w1_s5 <= a1_s4 + b1_s4 + r1_s4;
			w2_s5 <= a2_s4 + b2_s4 + r2_s4;
		end
	end

	// stage 6: choose
	logic v_s6;
	logic [1:0] dir_s6;
	logic [WW-1:0] diff_s6;
	logic [1:0] dir_c;
	logic [WW-1:0] best_c;
	always_comb begin
		dir_c = DIR_NONE;
		best_c = w0_s5;
		priority if (skip_s5) begin
			dir_c = DIR_NONE;
		end else if (w0_s5 <= w1_s5) begin
			if (!(w0_s5 <= w2_s5)) begin
				dir_c = DIR_RIGHT; best_c = w2_s5;
			end
		end else if (w2_s5 <= w1_s5) begin
			dir_c = DIR_RIGHT; best_c = w2_s5;
		end else begin
			dir_c = DIR_LEFT; best_c = w1_s5;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dir_s6 <= dir_c;
			diff_s6 <= w0_s5 - best_c;
		end
	end

	// output register
	logic [CHG_W-1:0] chg_q;
	logic [1:0] dir_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dir_q <= dir_s6;
			chg_q <= CHG_W'(0) - CHG_W'(diff_s6 >> (LAM_BITS + 1));
		end
	end
	assign m_axis_tdata = {5'b0, chg_q};
	assign m_axis_tuser = dir_q;
endmodule

@@ tb/nni_swap_check.sv @@
// checker for the nearest neighbor interchange test block: predicts each result
// from the accepted input transactions and compares it. depends on nni_pkg
module nni_swap_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [239:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	output int           fail_count,
	output int           pending
);
	import nni_pkg::*;

	typedef struct packed {
		logic [1:0]       dir;
		logic [CHG_W-1:0] change;
	} swap_result_t;

	swap_result_t swap_q[$];

	function automatic logic [63:0] leaf_count(input logic [SIZE_W-1:0] s);
		if (s == 0)
			return 64'd1;
		if (s > 1024)
			return 64'd1024;
		return 64'(s);
	endfunction

	function automatic logic [63:0] twice_weight(input logic [63:0] lam, input logic [63:0] p,
			input logic [63:0] q, input logic [63:0] r);
		return lam * p + ((64'd1 << LAM_BITS) - lam) * q + (r << LAM_BITS);
	endfunction

	function automatic swap_result_t best_swap(input logic [239:0] d, input logic [1:0] u);
		swap_result_t res;
		logic [63:0] a, b, c, e, lr, lu, ld, ru, rd, du;
		logic [63:0] l0, l1, l2, w0, w1, w2, best;
		res = '0;
		if (u != 2'b00)
			return res;
		a  = leaf_count(d[10:0]);
		b  = leaf_count(d[21:11]);
		c  = leaf_count(d[32:22]);
		e  = leaf_count(d[43:33]);
		lr = 64'(d[75:44]);
		lu = 64'(d[107:76]);
		ld = 64'(d[139:108]);
		ru = 64'(d[171:140]);
		rd = 64'(d[203:172]);
		du = 64'(d[235:204]);
		l0 = ((b * c + a * e) << LAM_BITS) / ((a + b) * (c + e));
		l1 = ((b * c + a * e) << LAM_BITS) / ((a + c) * (b + e));
		l2 = ((c * e + a * b) << LAM_BITS) / ((a + e) * (b + c));
		w0 = twice_weight(l0, lu + rd, ru + ld, du + lr);
		w1 = twice_weight(l1, du + lr, ru + ld, lu + rd);
		w2 = twice_weight(l2, lu + rd, du + lr, ru + ld);
		if (w0 <= w1 && w0 <= w2)
			return res;
		if (w0 <= w1 || w2 <= w1) begin
			res.dir = DIR_RIGHT;
			best = w2;
		end else begin
			res.dir = DIR_LEFT;
			best = w1;
		end
		res.change = CHG_W'(64'd0 - ((w0 - best) >> (LAM_BITS + 1)));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		swap_result_t exp_r;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			swap_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				swap_q.push_back(best_swap(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (swap_q.size() == 0) begin
					$error("unexpected result transaction");
					errs++;
				end else begin
					exp_r = swap_q.pop_front();
					if (m_axis_tuser != exp_r.dir) begin
						$error("swap_direction expected %0d actual %0d", exp_r.dir, m_axis_tuser);
						errs++;
					end
					if (m_axis_tdata[CHG_W-1:0] != exp_r.change) begin
						$error("weight_change expected %0d actual %0d",
							$signed(exp_r.change), $signed(m_axis_tdata[CHG_W-1:0]));
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			pending <= swap_q.size();
		end
	end
endmodule

@@ tb/nni_swap_test_test.sv @@
// testbench top for nni_swap_test: drives directed and random edges with
// random idling and one long stall, verdict from nni_swap_check. depends on nni_pkg
module nni_swap_test_test;
	import nni_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	int           fail_count;
	int           pending;
	int           idle_cycles = 0;
	bit           hold_off;

	localparam int LATENCY = 26;
	localparam int WATCHDOG = 2000;

	nni_swap_test u_dut (.*);

	nni_swap_check u_check (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0: return SIZE_W'($urandom);
			1: return SIZE_W'($urandom_range(1000, 1024));
			default: return SIZE_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [DIST_W-1:0] rand_dist(input logic [DIST_W-1:0] base);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return base + $urandom_range(0, 32'h000F_FFFF);
		endcase
	endfunction

	// valid stays high between transactions that follow with no gap
	task automatic send_edge(input logic [1:0] leaf, input logic [43:0] sizes,
			input logic [191:0] dists);
		int n;
		n = $urandom_range(0, 4);
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= leaf;
		s_axis_tdata  <= {4'd0, dists, sizes};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random idling plus one long stall when asked
	initial begin
		int n;
		bit stalled;
		m_axis_tready = 0;
		stalled = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = $urandom_range(0, 4);
			if (hold_off && !stalled) begin
				stalled = 1;
				m_axis_tready <= 0;
				repeat (120) @(negedge clk);
			end else if (n > 0) begin
				m_axis_tready <= 0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		logic [191:0] dists;
		logic [DIST_W-1:0] base;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		hold_off = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, leaf flags, ties, zero and oversize counts
		send_edge(2'b01, {11'd5, 11'd6, 11'd7, 11'd8}, {6{32'h1234_5678}});
		send_edge(2'b10, {11'd5, 11'd6, 11'd7, 11'd8}, {6{32'h0001_0000}});
		send_edge(2'b11, {4{11'h7FF}}, {6{32'hFFFF_FFFF}});
		send_edge(2'b00, {4{11'd1}}, {6{32'h0001_0000}});
		send_edge(2'b00, {4{11'd0}}, {6{32'h0}});
		send_edge(2'b00, {4{11'h7FF}}, {6{32'hFFFF_FFFF}});
		send_edge(2'b00, {4{11'd1024}}, {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF});
		send_edge(2'b00, {11'd1, 11'd1024, 11'd1, 11'd1024},
			{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
		send_edge(2'b00, {11'd3, 11'd1, 11'd1025, 11'd2},
			{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0});
		send_edge(2'b00, {11'd2, 11'd2, 11'd2, 11'd2},
			{32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0003_0000,
			32'h0001_0000});
		send_edge(2'b00, {11'd2, 11'd2, 11'd2, 11'd2},
			{32'h0001_0000, 32'h0005_0000, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000,
			32'h0001_0000});
		for (int i = 0; i < 6; i++)
			send_edge(2'b00, {4{11'd4}}, 192'(32'hFFFF_FFFF) << (32 * i));

		// pause until every result is back
		s_axis_tvalid <= 0;
		wait (pending == 0);
		@(negedge clk);
		// long receiver stall while the sender keeps going
		hold_off = 1;
		for (int i = 0; i < 600; i++) begin
			base = $urandom;
			for (int k = 0; k < 6; k++)
				dists[32*k +: 32] = rand_dist(base);
			send_edge(($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b00,
				{rand_size(), rand_size(), rand_size(), rand_size()}, dists);
		end
		s_axis_tvalid <= 0;

		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
